@@ rtl/rnqc_pkg.sv @@
`default_nettype none
package rnqc_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 13;
    localparam int LIMIT_W = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 13'd8191;

    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;  // (
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;  // )
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;  // [
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;  // ]
    localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;  // {
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;  // }
    localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;  // backslash
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;

    typedef enum logic [5:0] {
        MODE_NORMAL      = 6'b000001,
        MODE_ESC         = 6'b000010,
        MODE_CLASS       = 6'b000100,
        MODE_CLASS_ESC   = 6'b001000,
        MODE_BRACE       = 6'b010000,
        MODE_AFTER_CLOSE = 6'b100000
    } scan_mode_t;

    // lookahead tracking after '('
    typedef enum logic [1:0] {
        LA_NONE  = 2'd0,
        LA_PAREN = 2'd1,
        LA_QUEST = 2'd2
    } look_t;

    // one operation on the whole cell chain per cycle
    typedef struct packed {
        logic push;
        logic pop;
        logic mark;
    } stk_op_t;

endpackage
`default_nettype wire

@@ rtl/rnqc_cell.sv @@
`default_nettype none
module rnqc_cell
    import rnqc_pkg::*;
(
    input  wire logic    aclk,
    input  wire stk_op_t op,
    input  wire logic    top_cell,
    input  wire logic    up_bit,
    input  wire logic    down_bit,
    output logic         bit_q
);

    logic bit_reg;
    logic bit_next;

    always_comb begin
        bit_next = bit_reg;
        if (op.push) begin
            bit_next = up_bit;
        end else if (op.pop) begin
            bit_next = down_bit;
        end
        // mark applies to the top after any pop in the same cycle
        if (op.mark && top_cell) begin
            bit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg <= bit_next;
    end

    assign bit_q = bit_reg;

endmodule
`default_nettype wire

@@ rtl/regex_nested_quantifier_check_unit.sv @@
`default_nettype none
// Checks a regex pattern, one byte per s_ transaction (s_tlast on the final byte), and
// returns one m_ transaction per pattern with bit 0 of m_tdata set when the pattern is safe:
// not longer than max_length and no quantified group that itself holds a quantifier.
// Escapes, character classes and brace counts are skipped; (?=, (?! and (?< groups are not
// tracked. The group stack is a chain of STACK_DEPTH one-bit cells that shift as a whole on
// push and pop; nesting deeper than STACK_DEPTH rejects the pattern. One byte is taken per
// cycle while s_tready is high; the scanner is combinational. The verdict is registered in
// the output register, or in a spare one while the output holds one, so s_tready drops only
// while two results wait, and never depends on m_tready in the same cycle. The user must
// write max_length on the cfg_ channel only while no pattern is in flight (not enforced).
module regex_nested_quantifier_check_unit
    import rnqc_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // [7:0] char_code
    input  wire logic               s_tlast,    // last
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,    // [0] safe, [7:1] zero
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data    // max_length
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    logic [LIMIT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    scan_mode_t         mode_reg, mode_next;
    look_t              look_reg, look_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               cq_reg, cq_next;
    logic               rej_reg, rej_next;
    logic               out_valid_reg, out_valid_next;
    logic               safe_reg, safe_next;
    logic               spare_valid_reg, spare_valid_next;
    logic               spare_safe_reg, spare_safe_next;

    stk_op_t            scan_op, cell_op;
    logic [STACK_DEPTH-1:0] cell_bits;

    logic [CHAR_W-1:0]  c;
    logic               in_fire;
    logic               done;
    logic               skip;
    logic               verdict;

    assign s_tready  = !spare_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign c         = s_tdata;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, safe_reg};

    always_comb begin
        count_next = count_reg;
        mode_next  = mode_reg;
        look_next  = look_reg;
        depth_next = depth_reg;
        cq_next    = cq_reg;
        rej_next   = rej_reg;
        scan_op    = '0;
        done       = 1'b0;
        skip       = 1'b0;
        verdict    = 1'b0;

        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + 1'b1;
        end

        if (!rej_reg) begin
            if (look_reg == LA_QUEST) begin
                look_next = LA_NONE;
                if (c inside {CH_EQUAL, CH_BANG, CH_LESS}) begin
                    // undo the provisional push, then mark the enclosing group
                    if (depth_reg != '0) begin
                        depth_next  = depth_reg - 1'b1;
                        scan_op.pop = 1'b1;
                    end
                    scan_op.mark = (depth_next != '0);
                    done = 1'b1;
                end
            end else if (look_reg == LA_PAREN) begin
                look_next = LA_NONE;
                if (c == CH_QUEST) begin
                    scan_op.mark = (depth_reg != '0);
                    look_next    = LA_QUEST;
                    done = 1'b1;
                end
            end

            if (!done) begin
                case (mode_reg)
                    MODE_ESC: begin
                        mode_next = MODE_NORMAL;
                        skip = 1'b1;
                    end
                    MODE_CLASS: begin
                        if (c == CH_BSLASH) begin
                            mode_next = MODE_CLASS_ESC;
                        end else if (c == CH_RBRACK) begin
                            mode_next = MODE_NORMAL;
                        end
                        skip = 1'b1;
                    end
                    MODE_CLASS_ESC: begin
                        mode_next = MODE_CLASS;
                        skip = 1'b1;
                    end
                    MODE_BRACE: begin
                        if (c == CH_RBRACE) begin
                            mode_next = MODE_NORMAL;
                        end
                        skip = 1'b1;
                    end
                    MODE_AFTER_CLOSE: begin
                        mode_next = MODE_NORMAL;
                        cq_next   = 1'b0;
                        if (cq_reg && (c inside {CH_PLUS, CH_STAR, CH_QUEST, CH_LBRACE})) begin
                            rej_next = 1'b1;
                            skip = 1'b1;
                        end
                    end
                    default: begin
                        mode_next = MODE_NORMAL;
                    end
                endcase

                if (!skip) begin
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else if (c == CH_LBRACK) begin
                        mode_next = MODE_CLASS;
                    end else if (c == CH_LPAREN) begin
                        if (depth_reg >= DEPTH_FULL) begin
                            rej_next = 1'b1;
                        end else begin
                            scan_op.push = 1'b1;
                            depth_next   = depth_reg + 1'b1;
                            look_next    = LA_PAREN;
                        end
                    end else if (c == CH_RPAREN) begin
                        if (depth_reg != '0) begin
                            depth_next  = depth_reg - 1'b1;
                            scan_op.pop = 1'b1;
                            cq_next     = cell_bits[0];
                            mode_next   = MODE_AFTER_CLOSE;
                        end
                    end else if (c inside {CH_PLUS, CH_STAR, CH_QUEST}) begin
                        scan_op.mark = (depth_reg != '0);
                    end else if (c == CH_LBRACE) begin
                        scan_op.mark = (depth_reg != '0);
                        mode_next    = MODE_BRACE;
                    end
                end
            end
        end

        if (s_tlast) begin
            verdict    = !rej_next && (count_next <= {1'b0, limit_reg});
            count_next = '0;
            mode_next  = MODE_NORMAL;
            look_next  = LA_NONE;
            depth_next = '0;
            cq_next    = 1'b0;
            rej_next   = 1'b0;
        end
    end

    assign cell_op = in_fire ? scan_op : stk_op_t'('0);

    // two-entry result buffer: output register plus a spare behind it
    always_comb begin
        out_valid_next   = out_valid_reg;
        safe_next        = safe_reg;
        spare_valid_next = spare_valid_reg;
        spare_safe_next  = spare_safe_reg;
        if (m_tready) begin
            out_valid_next   = spare_valid_reg;
            safe_next        = spare_safe_reg;
            spare_valid_next = 1'b0;
        end
        if (in_fire && s_tlast) begin
            if (out_valid_next) begin
                spare_valid_next = 1'b1;
                spare_safe_next  = verdict;
            end else begin
                out_valid_next = 1'b1;
                safe_next      = verdict;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg       <= LIMIT_RESET;
            count_reg       <= '0;
            mode_reg        <= MODE_NORMAL;
            look_reg        <= LA_NONE;
            depth_reg       <= '0;
            cq_reg          <= 1'b0;
            rej_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (in_fire) begin
                count_reg <= count_next;
                mode_reg  <= mode_next;
                look_reg  <= look_next;
                depth_reg <= depth_next;
                cq_reg    <= cq_next;
                rej_reg   <= rej_next;
            end
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        safe_reg       <= safe_next;
        spare_safe_reg <= spare_safe_next;
    end

    // cell 0 is the stack top; a push shifts a zero in at the top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic up_b;
        logic down_b;
        if (i == 0) begin : g_top
            assign up_b = 1'b0;
        end else begin : g_mid
            assign up_b = cell_bits[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign down_b = cell_bits[i];
        end else begin : g_inner
            assign down_b = cell_bits[i+1];
        end
        rnqc_cell u_cell (
            .aclk     (aclk),
            .op       (cell_op),
            .top_cell (i == 0),
            .up_bit   (up_b),
            .down_bit (down_b),
            .bit_q    (cell_bits[i])
        );
    end

endmodule
`default_nettype wire
